[hw/rtl/uart_bds_pkg.sv]
// ----------------------------------------------------------------------------
// UART baud divisor search - shared package
// Payload types, command/status types and constants used by the block.
// ----------------------------------------------------------------------------
package uart_bds_pkg;

    localparam int MIN_RATIO     = 4;
    localparam int MAX_RATIO     = 32;
    localparam int RATIO_W       = $clog2(MAX_RATIO + 1);
    localparam int OUT_RATIO_W   = 6;

    localparam int DATA_W        = 32;
    localparam int BAUD_W        = 27;
    localparam int DIVISOR_W     = 16;
    localparam int DIV_CNT_W     = $clog2(DATA_W);

    localparam int PCT_DIVISOR   = 100;
    localparam int PCT_LIMIT     = 3;

    // floor(x / 100) for x < 2^27 as (x * ceil(2^33 / 100)) >> 33
    localparam int PCT_RECIP     = 85899346;
    localparam int PCT_RECIP_W   = 27;
    localparam int PCT_SHIFT     = 33;
    localparam int PCT_PROD_W    = BAUD_W + PCT_RECIP_W;

    localparam int BOTH_EDGE_MIN = 4;
    localparam int BOTH_EDGE_MAX = 7;

    localparam logic [1:0] PARITY_NONE = 2'd0;
    localparam logic [1:0] PARITY_ODD  = 2'd1;
    localparam logic [1:0] PARITY_EVEN = 2'd2;

    localparam logic [3:0] DATA_BITS_8 = 4'd8;
    localparam logic [3:0] DATA_BITS_9 = 4'd9;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAUD_ERR = 2'd1,
        STATUS_BAD_BITS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DSEL_FLOOR,
        DSEL_LOW,
        DSEL_HIGH
    } div_sel_t;

    typedef struct packed {
        logic [31:0] clock_hz;
        logic [26:0] baud_rate;
        logic [1:0]  parity_mode;
        logic [3:0]  data_bits;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  oversample_ratio;
        logic [15:0] baud_divisor;
        logic        both_edge;
        logic        parity_enable;
        logic        parity_odd;
        logic        nine_bit_frame;
    } rsp_item_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_floor;
        logic     cap_low;
        logic     cap_high;
        logic     choose;
        logic     cap_thresh;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_ratio;
    } dp_status_t;

endpackage

[hw/rtl/uart_baud_divisor_search_unit.sv]
// ----------------------------------------------------------------------------
// UART baud divisor search unit
// Finds the oversampling ratio and baud divisor closest to a wanted baud
// rate and decodes the parity and frame flags.
// ----------------------------------------------------------------------------
// One request is worked on at a time. Every ratio from 4 to 32 costs three
// divisions on a single shared bit-serial divider plus a compare step; the
// 3 percent error limit then comes from a constant reciprocal multiply, and a
// last step loads the result register. The result sits in an output register,
// so a new request is taken while the previous result still waits; a result
// stall holds the unit only once the next result is ready.
module uart_baud_divisor_search_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  uart_bds_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output uart_bds_pkg::rsp_item_t rsp
);
    import uart_bds_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    uart_bds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    uart_bds_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted but unit did not go busy");

    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result offered without a transaction in progress");

    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.oversample_ratio == '0) ||
                      ((rsp.oversample_ratio >= OUT_RATIO_W'(MIN_RATIO)) &&
                       (rsp.oversample_ratio <= OUT_RATIO_W'(MAX_RATIO))))
        else $error("reported ratio out of range");

    a_both_edge: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.both_edge |-> rsp.baud_divisor != '0 ||
                                       rsp.oversample_ratio != '0)
        else $error("both-edge flag set with no ratio chosen");

endmodule

[hw/rtl/uart_bds_div.sv]
// ----------------------------------------------------------------------------
// UART baud divisor search - divider
// Restoring unsigned 32/32 divider, one quotient bit per cycle.
// A zero denominator yields an all-ones quotient.
// ----------------------------------------------------------------------------
module uart_bds_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [uart_bds_pkg::DATA_W-1:0] num,
    input  logic [uart_bds_pkg::DATA_W-1:0] den,
    output logic [uart_bds_pkg::DATA_W-1:0] quo,
    output logic                     done
);
    import uart_bds_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    den_reg, den_next;
    logic [DATA_W:0]      rem_sh;
    logic [DATA_W+1:0]    diff;
    logic                 ge;

    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    assign ge     = ~diff[DATA_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

[hw/rtl/uart_bds_dp.sv]
// ----------------------------------------------------------------------------
// UART baud divisor search - datapath
// Request registers, candidate products, error tracking, best choice and
// the result register. Owns the shared divider.
// ----------------------------------------------------------------------------
module uart_bds_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  uart_bds_pkg::req_item_t  req,
    input  uart_bds_pkg::dp_cmd_t    cmd,
    output uart_bds_pkg::dp_status_t sts,
    output uart_bds_pkg::rsp_item_t  rsp
);
    import uart_bds_pkg::*;

    logic [DATA_W-1:0]    clk_reg;
    logic [BAUD_W-1:0]    baud_reg;
    logic [1:0]           par_reg;
    logic [3:0]           bits_reg;
    logic [RATIO_W-1:0]   r_reg;
    logic [DIVISOR_W-1:0] d_reg;
    logic [DATA_W-1:0]    e0_reg;
    logic [DATA_W-1:0]    e1_reg;
    logic [DATA_W-1:0]    best_err_reg;
    logic [RATIO_W-1:0]   best_r_reg;
    logic [DIVISOR_W-1:0] best_d_reg;
    logic [DATA_W-1:0]    thresh_reg;
    rsp_item_t            rsp_reg;

    logic [DATA_W-1:0]    div_num;
    logic [DATA_W-1:0]    div_den;
    logic [DATA_W-1:0]    div_q;
    logic                 div_done;
    logic [DATA_W-1:0]    baud_ext;
    logic                 pick_high;
    logic [DATA_W-1:0]    cand_err;
    logic [DIVISOR_W-1:0] cand_d;
    logic [PCT_PROD_W-1:0]           pct_prod;
    logic [PCT_PROD_W-PCT_SHIFT-1:0] pct_q;
    rsp_item_t            rsp_next;

    assign baud_ext = DATA_W'(baud_reg);
    assign div_num  = clk_reg;

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_FLOOR: div_den = baud_ext * DATA_W'(r_reg);
            DSEL_LOW:   div_den = DATA_W'(r_reg) * DATA_W'(d_reg);
            DSEL_HIGH:  div_den = DATA_W'(r_reg) * (DATA_W'(d_reg) + DATA_W'(1));
            default:    div_den = '0;
        endcase
    end

    uart_bds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_q),
        .done  (div_done)
    );

    assign pick_high = e0_reg > e1_reg;
    assign cand_err  = pick_high ? e1_reg : e0_reg;
    assign cand_d    = pick_high ? d_reg + 1'b1 : d_reg;

    // baud / 100 by reciprocal multiply
    assign pct_prod = PCT_PROD_W'(baud_reg) * PCT_PROD_W'(PCT_RECIP);
    assign pct_q    = pct_prod[PCT_PROD_W-1:PCT_SHIFT];

    always_comb
    begin
        rsp_next.status = (best_err_reg > thresh_reg) ? STATUS_BAUD_ERR :
                          (bits_reg != DATA_BITS_8 && bits_reg != DATA_BITS_9) ?
                          STATUS_BAD_BITS : STATUS_OK;
        rsp_next.oversample_ratio = OUT_RATIO_W'(best_r_reg);
        rsp_next.baud_divisor     = best_d_reg;
        rsp_next.both_edge        = (best_r_reg >= RATIO_W'(BOTH_EDGE_MIN)) &&
                                    (best_r_reg <= RATIO_W'(BOTH_EDGE_MAX));
        rsp_next.parity_enable    = (par_reg == PARITY_ODD) || (par_reg == PARITY_EVEN);
        rsp_next.parity_odd       = (par_reg == PARITY_ODD);
        rsp_next.nine_bit_frame   = (bits_reg == DATA_BITS_9) ||
                                    ((bits_reg == DATA_BITS_8) && (par_reg != PARITY_NONE));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            clk_reg      <= req.clock_hz;
            baud_reg     <= req.baud_rate;
            par_reg      <= req.parity_mode;
            bits_reg     <= req.data_bits;
            r_reg        <= RATIO_W'(MIN_RATIO);
            best_err_reg <= DATA_W'(req.baud_rate);
            best_r_reg   <= '0;
            best_d_reg   <= '0;
        end
        if (cmd.cap_floor)
            d_reg <= (div_q[DIVISOR_W-1:0] == '0) ? DIVISOR_W'(1) : div_q[DIVISOR_W-1:0];
        if (cmd.cap_low)
            e0_reg <= div_q - baud_ext;
        if (cmd.cap_high)
            e1_reg <= baud_ext - div_q;
        if (cmd.choose)
        begin
            if (cand_err <= best_err_reg)
            begin
                best_err_reg <= cand_err;
                best_r_reg   <= r_reg;
                best_d_reg   <= cand_d;
            end
            if (r_reg != RATIO_W'(MAX_RATIO))
                r_reg <= r_reg + 1'b1;
        end
        if (cmd.cap_thresh)
            thresh_reg <= DATA_W'(pct_q) * DATA_W'(PCT_LIMIT);
        if (cmd.load_out)
            rsp_reg <= rsp_next;
    end

    assign sts.div_done   = div_done;
    assign sts.last_ratio = (r_reg == RATIO_W'(MAX_RATIO));
    assign rsp            = rsp_reg;

endmodule

[hw/rtl/uart_bds_ctrl.sv]
// ----------------------------------------------------------------------------
// UART baud divisor search - controller
// Sequences the three divisions per ratio, the error limit step and
// the result handshake.
// ----------------------------------------------------------------------------
module uart_bds_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    input  uart_bds_pkg::dp_status_t sts,
    output uart_bds_pkg::dp_cmd_t    cmd
);
    import uart_bds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FLOOR_GO,
        S_FLOOR_WAIT,
        S_LOW_GO,
        S_LOW_WAIT,
        S_HIGH_GO,
        S_HIGH_WAIT,
        S_CHOOSE,
        S_LIMIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = DSEL_FLOOR;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FLOOR_GO;
                end
            end
            S_FLOOR_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_FLOOR;
                state_next    = S_FLOOR_WAIT;
            end
            S_FLOOR_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_floor = 1'b1;
                    state_next    = S_LOW_GO;
                end
            end
            S_LOW_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_LOW;
                state_next    = S_LOW_WAIT;
            end
            S_LOW_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_low = 1'b1;
                    state_next  = S_HIGH_GO;
                end
            end
            S_HIGH_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_HIGH;
                state_next    = S_HIGH_WAIT;
            end
            S_HIGH_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_high = 1'b1;
                    state_next   = S_CHOOSE;
                end
            end
            S_CHOOSE:
            begin
                cmd.choose = 1'b1;
                state_next = sts.last_ratio ? S_LIMIT : S_FLOOR_GO;
            end
            S_LIMIT:
            begin
                cmd.cap_thresh = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        rsp_valid_next = cmd.load_out | (rsp_valid_reg & rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// UART baud divisor search unit - testbench
// Sends divisor search requests through the request channel and checks each
// response against an in-bench search over every oversampling ratio. A
// directed set covers the field extremes, every parity mode, unsupported bit
// counts, combined faults and a zero baud rate. Random requests then run
// across phases with and without sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

    import uart_bds_pkg::*;

    localparam logic [1:0] PARITY_RSVD = 2'd3;
    localparam int         SEARCH_CYCLES = 3100;
    localparam int         RANDOM_PER_PHASE = 30;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    req_item_t   req_backlog[$];
    rsp_item_t   rsp_awaited[$];
    rsp_item_t   want_rsp;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int          phase;

    uart_baud_divisor_search_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Unsigned divide; divide by zero gives all ones
    function automatic logic [31:0] quotient(input logic [31:0] num, input logic [31:0] den);
        return (den == 32'd0) ? 32'hFFFF_FFFF : num / den;
    endfunction

    function automatic rsp_item_t search_divisor(input req_item_t q);
        logic [31:0] clk_hz;
        logic [31:0] baud;
        logic [31:0] best_err;
        logic [31:0] best_r;
        logic [31:0] best_d;
        logic [31:0] r;
        logic [31:0] d;
        logic [31:0] e_lo;
        logic [31:0] e_hi;
        rsp_item_t   o;
        clk_hz   = q.clock_hz;
        baud     = {5'd0, q.baud_rate};
        best_err = baud;
        best_r   = 32'd0;
        best_d   = 32'd0;
        for (r = MIN_RATIO; r <= MAX_RATIO; r++)
        begin
            d = quotient(clk_hz, baud * r) & 32'hFFFF;
            if (d == 32'd0)
                d = 32'd1;
            e_lo = quotient(clk_hz, r * d) - baud;
            e_hi = baud - quotient(clk_hz, r * (d + 32'd1));
            if (e_lo > e_hi)
            begin
                e_lo = e_hi;
                d = (d + 32'd1) & 32'hFFFF;
            end
            if (e_lo <= best_err)
            begin
                best_err = e_lo;
                best_r   = r;
                best_d   = d;
            end
        end
        if (best_err > (baud / PCT_DIVISOR) * PCT_LIMIT)
            o.status = STATUS_BAUD_ERR;
        else if (q.data_bits != DATA_BITS_8 && q.data_bits != DATA_BITS_9)
            o.status = STATUS_BAD_BITS;
        else
            o.status = STATUS_OK;
        o.oversample_ratio = best_r[5:0];
        o.baud_divisor     = best_d[15:0];
        o.both_edge        = (best_r >= BOTH_EDGE_MIN && best_r <= BOTH_EDGE_MAX);
        o.parity_enable    = (q.parity_mode == PARITY_ODD || q.parity_mode == PARITY_EVEN);
        o.parity_odd       = (q.parity_mode == PARITY_ODD);
        o.nine_bit_frame   = (q.data_bits == DATA_BITS_9) ||
                             (q.data_bits == DATA_BITS_8 && q.parity_mode != PARITY_NONE);
        return o;
    endfunction

    function automatic req_item_t random_request();
        req_item_t   q;
        int unsigned pick;
        int unsigned base;
        pick = $urandom_range(0, 9);
        q.parity_mode = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0)
            q.data_bits = 4'($urandom_range(8, 9));
        else
            q.data_bits = 4'($urandom_range(0, 15));
        if (pick < 6)
        begin
            // realistic clock with a baud rate near an exact ratio * divisor
            q.clock_hz  = $urandom_range(1_000_000, 200_000_000);
            base        = q.clock_hz / ($urandom_range(4, 32) * $urandom_range(1, 200));
            q.baud_rate = 27'(base + base * $urandom_range(0, 5) / 100);
        end
        else if (pick < 8)
        begin
            q.clock_hz  = $urandom;
            q.baud_rate = 27'($urandom);
        end
        else
        begin
            q.clock_hz  = $urandom >> $urandom_range(0, 31);
            q.baud_rate = 27'($urandom >> $urandom_range(5, 31));
        end
        return q;
    endfunction

    task automatic queue_req(input logic [31:0] clock_hz, input logic [26:0] baud,
                             input logic [1:0] parity, input logic [3:0] bits);
        req_item_t q;
        q.clock_hz    = clock_hz;
        q.baud_rate   = baud;
        q.parity_mode = parity;
        q.data_bits   = bits;
        req_backlog.push_back(q);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                rsp_awaited.push_back(search_divisor(req));
            if (!req_valid || !req_stall)
            begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req <= req_backlog.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_awaited.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response transaction: %h", rsp);
                end
                else
                begin
                    want_rsp = rsp_awaited.pop_front();
                    check_field("status", 32'(want_rsp.status), 32'(rsp.status));
                    check_field("oversample_ratio", 32'(want_rsp.oversample_ratio),
                                32'(rsp.oversample_ratio));
                    check_field("baud_divisor", 32'(want_rsp.baud_divisor),
                                32'(rsp.baud_divisor));
                    check_field("both_edge", 32'(want_rsp.both_edge), 32'(rsp.both_edge));
                    check_field("parity_enable", 32'(want_rsp.parity_enable),
                                32'(rsp.parity_enable));
                    check_field("parity_odd", 32'(want_rsp.parity_odd),
                                32'(rsp.parity_odd));
                    check_field("nine_bit_frame", 32'(want_rsp.nine_bit_frame),
                                32'(rsp.nine_bit_frame));
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (phase == 0)
            begin
                queue_req(32'd0, 27'd1, PARITY_NONE, DATA_BITS_8);
                queue_req(32'hFFFF_FFFF, 27'h7FF_FFFF, PARITY_ODD, DATA_BITS_9);
                queue_req(32'hFFFF_FFFF, 27'd1, PARITY_EVEN, DATA_BITS_8);
                queue_req(32'd0, 27'h7FF_FFFF, PARITY_NONE, DATA_BITS_9);
                queue_req(32'd48_000_000, 27'd0, PARITY_NONE, DATA_BITS_8);
                queue_req(32'd48_000_000, 27'd115_200, PARITY_NONE, DATA_BITS_8);
                queue_req(32'd48_000_000, 27'd115_200, PARITY_ODD, DATA_BITS_8);
                queue_req(32'd48_000_000, 27'd115_200, PARITY_EVEN, DATA_BITS_8);
                queue_req(32'd48_000_000, 27'd115_200, PARITY_RSVD, DATA_BITS_8);
                queue_req(32'd48_000_000, 27'd115_200, PARITY_RSVD, DATA_BITS_9);
                queue_req(32'd24_000_000, 27'd9_600, PARITY_NONE, DATA_BITS_9);
                queue_req(32'd80_000_000, 27'd4_000_000, PARITY_ODD, DATA_BITS_8);
                queue_req(32'd20_000_000, 27'd3_000_000, PARITY_EVEN, DATA_BITS_8);
                queue_req(32'd1_000, 27'd115_200, PARITY_NONE, 4'd5);
                queue_req(32'd48_000_000, 27'd115_200, PARITY_NONE, 4'd5);
                queue_req(32'd48_000_000, 27'd115_200, PARITY_EVEN, 4'd0);
                queue_req(32'd48_000_000, 27'd115_200, PARITY_ODD, 4'd15);
                queue_req(32'd100_000_000, 27'd921_600, PARITY_ODD, 4'd7);
                queue_req(32'd16_000_000, 27'd1_000_000, PARITY_NONE, DATA_BITS_8);
                queue_req(32'd32_000_000, 27'd1_000_000, PARITY_EVEN, DATA_BITS_9);
                queue_req(32'h7FFF_FFFF, 27'd12_345, PARITY_EVEN, 4'd6);
                queue_req(32'd19_200, 27'd300, PARITY_RSVD, 4'd5);
            end
            repeat (RANDOM_PER_PHASE) req_backlog.push_back(random_request());
            // hold off until every response of this phase is back
            do
                @(negedge clk);
            while (req_backlog.size() != 0 || req_valid || rsp_awaited.size() != 0);
        end
        repeat (SEARCH_CYCLES) @(negedge clk);
        if (mismatches == 0 && rsp_awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
